// ===== design/ssp_pkg.sv =====
// Shared constants for the segmented sieve prime tester.
package ssp_pkg;
  localparam int BASE_WORDS = 512;
  localparam int SEG_WORDS  = 1024;
  localparam int WORD_W     = 64;
  localparam int BASE_AW    = 9;
  localparam int SEG_AW     = 10;
  localparam int PRIME_W    = 17;
  localparam int PSQ_W      = 34;
  localparam int FILL_W     = 10;
endpackage

// ===== design/ssp_ram.sv =====
// Generic single-port RAM with registered read.
module ssp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/ssp_rem.sv =====
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module ssp_rem #(
  parameter int NW = 33,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] r_r;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [DW:0]   t;
  logic [DW:0]   t_sub;

  assign t     = {r_r, q_r[NW-1]};
  assign t_sub = t - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r <= num;
      r_r <= '0;
      d_r <= den;
    end else if (run_r) begin
      q_r <= q_r << 1;
      if (t >= {1'b0, d_r}) begin
        r_r <= t_sub[DW-1:0];
      end else begin
        r_r <= t[DW-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r;
endmodule

// ===== design/segmented_sieve_prime_test_top.sv =====
// Top level: sequencer of the segmented sieve prime tester.
//
// Usage: drive in_query_value and raise start; the query beat is taken at a
// clock edge with start high and busy low. The answer shows on out_is_prime
// for exactly one cycle, flagged by out_valid; the receiver cannot stall it.
// One query is in flight at a time; busy stays high until the answer is out.
// Values below 2, even values and values near the top of the range are
// answered from the check state without a lookup. Other values are looked
// up in the base bitmap or in the cached segment.
// The first real query also builds the base bitmap: a fill of all 512 words
// plus a read-modify-write per struck bit. A segment miss rebuilds the
// segment: a fill of all 1024 words, then per base prime a pass through the
// serial remainder unit when its square lies below the segment start, plus a
// read-modify-write per struck bit. The single-port bitmap memories make
// every bit clear a read then a write of one 64-bit word.
// Reset (synchronous, rst_n low) drops both bitmaps as invalid; they are
// rebuilt on demand.
module segmented_sieve_prime_test_top #(
  parameter int VALUE_BITS   = 32,
  parameter int BASE_LIMIT   = 65535,
  parameter int SEGMENT_SPAN = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_query_value,
  output logic        out_valid,
  output logic        out_is_prime
);
  import ssp_pkg::*;

  localparam int VW = VALUE_BITS;
  localparam logic [31:0]   REJ    = 32'((64'd1 << VW) - 64'd4);
  localparam logic [VW-1:0] MXV    = '1;
  localparam logic [VW-1:0] LIM_HI = VW'((64'd1 << VW) - 64'd1 - 64'(SEGMENT_SPAN));
  localparam logic [VW-1:0] SPANV  = VW'(SEGMENT_SPAN);
  localparam logic [VW-1:0] BASEV  = VW'(BASE_LIMIT);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CHK   = 5'd1;
  localparam logic [4:0] S_BFILL = 5'd2;
  localparam logic [4:0] S_BPSQ  = 5'd3;
  localparam logic [4:0] S_BPCMP = 5'd4;
  localparam logic [4:0] S_BPRD  = 5'd5;
  localparam logic [4:0] S_BJ    = 5'd6;
  localparam logic [4:0] S_BRMW  = 5'd7;
  localparam logic [4:0] S_LOOK  = 5'd8;
  localparam logic [4:0] S_BANS  = 5'd9;
  localparam logic [4:0] S_SEND  = 5'd10;
  localparam logic [4:0] S_SFILL = 5'd11;
  localparam logic [4:0] S_SPSQ  = 5'd12;
  localparam logic [4:0] S_SPCMP = 5'd13;
  localparam logic [4:0] S_SPRD  = 5'd14;
  localparam logic [4:0] S_SDIV  = 5'd15;
  localparam logic [4:0] S_SWAIT = 5'd16;
  localparam logic [4:0] S_SJ    = 5'd17;
  localparam logic [4:0] S_SRMW  = 5'd18;
  localparam logic [4:0] S_SLOOK = 5'd19;
  localparam logic [4:0] S_SANS  = 5'd20;

  logic [4:0]         state_r, state_nxt;
  logic [31:0]        n_r;
  logic [VW-1:0]      nv;
  logic               base_ready_r, base_ready_nxt;
  logic               seg_valid_r, seg_valid_nxt;
  logic [VW-1:0]      seg_start_r, seg_start_nxt;
  logic [VW-1:0]      seg_end_r;
  logic [FILL_W-1:0]  cnt_r;
  logic [PRIME_W-1:0] p_r;
  logic [PSQ_W-1:0]   pp_r;
  logic [VW:0]        j_r;
  logic               out_valid_r;
  logic               out_prime_r;

  logic [BASE_AW-1:0] b_addr;
  logic               b_we;
  logic [WORD_W-1:0]  b_wdata, b_rdata;
  logic [SEG_AW-1:0]  s_addr;
  logic               s_we;
  logic [WORD_W-1:0]  s_wdata, s_rdata;
  logic [15:0]        j_idx, n_idx;
  logic [PRIME_W-1:0] p_next;
  logic [VW:0]        x_num;
  logic               rem_go, rem_done;
  logic [PRIME_W-1:0] rem_val;
  logic [VW-1:0]      old_start;
  logic               reject;

  assign nv        = n_r[VW-1:0];
  assign j_idx     = 16'(j_r - {1'b0, seg_start_r});
  assign n_idx     = 16'(nv - seg_start_r);
  assign p_next    = (p_r == PRIME_W'(2)) ? PRIME_W'(3) : p_r + PRIME_W'(2);
  assign x_num     = {1'b0, seg_start_r} + (VW+1)'(p_r) - (VW+1)'(1);
  assign old_start = seg_valid_r ? seg_start_r : '0;
  assign reject    = (n_r < 32'd2) || !n_r[0] || (n_r >= REJ);
  assign rem_go    = (state_r == S_SDIV) && (pp_r < PSQ_W'(seg_start_r));

  ssp_ram #(.WIDTH(WORD_W), .DEPTH(BASE_WORDS)) u_base (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
  );

  ssp_ram #(.WIDTH(WORD_W), .DEPTH(SEG_WORDS)) u_seg (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  ssp_rem #(.NW(VW + 1), .DW(PRIME_W)) u_rem (
    .clk(clk), .rst_n(rst_n), .go(rem_go), .num(x_num), .den(p_r),
    .done(rem_done), .rem(rem_val)
  );

  // memory address and write muxes
  always_comb begin
    b_addr  = '0;
    b_we    = 1'b0;
    b_wdata = b_rdata & ~(WORD_W'(1) << j_r[6:1]);
    s_addr  = '0;
    s_we    = 1'b0;
    s_wdata = s_rdata & ~(WORD_W'(1) << j_idx[5:0]);
    case (state_r)
      S_BFILL: begin
        b_addr  = cnt_r[BASE_AW-1:0];
        b_we    = 1'b1;
        b_wdata = (cnt_r == '0) ? ~WORD_W'(1) : '1;
      end
      S_BPCMP, S_SPCMP: b_addr = p_r[15:7];
      S_BJ:             b_addr = j_r[15:7];
      S_BRMW: begin
        b_addr = j_r[15:7];
        b_we   = 1'b1;
      end
      S_LOOK: b_addr = n_r[15:7];
      S_SFILL: begin
        s_addr  = cnt_r;
        s_we    = 1'b1;
        s_wdata = '1;
      end
      S_SJ:    s_addr = j_idx[15:6];
      S_SRMW: begin
        s_addr = j_idx[15:6];
        s_we   = 1'b1;
      end
      S_SLOOK: s_addr = n_idx[15:6];
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    base_ready_nxt = base_ready_r;
    seg_valid_nxt  = seg_valid_r;
    seg_start_nxt  = seg_start_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_CHK;
      S_CHK: begin
        if (reject)             state_nxt = S_IDLE;
        else if (!base_ready_r) state_nxt = S_BFILL;
        else                    state_nxt = S_LOOK;
      end
      S_BFILL: if (cnt_r == FILL_W'(BASE_WORDS - 1)) state_nxt = S_BPSQ;
      S_BPSQ:  state_nxt = S_BPCMP;
      S_BPCMP: begin
        if (pp_r <= PSQ_W'(BASE_LIMIT)) begin
          state_nxt = S_BPRD;
        end else begin
          base_ready_nxt = 1'b1;
          state_nxt      = S_LOOK;
        end
      end
      S_BPRD:  state_nxt = b_rdata[p_r[6:1]] ? S_BJ : S_BPSQ;
      S_BJ:    state_nxt = (j_r <= (VW+1)'(BASE_LIMIT)) ? S_BRMW : S_BPSQ;
      S_BRMW:  state_nxt = S_BJ;
      S_LOOK: begin
        if (nv < BASEV) begin
          state_nxt = S_BANS;
        end else if (seg_valid_r && nv >= seg_start_r && nv <= seg_end_r) begin
          state_nxt = S_SLOOK;
        end else begin
          seg_valid_nxt = 1'b0;
          state_nxt     = S_SEND;
          if (nv > old_start)   seg_start_nxt = (nv > LIM_HI) ? LIM_HI : nv;
          else if (nv < SPANV)  seg_start_nxt = BASEV - VW'(1);
          else                  seg_start_nxt = nv - (SPANV - VW'(2));
        end
      end
      S_BANS:  state_nxt = S_IDLE;
      S_SEND:  state_nxt = S_SFILL;
      S_SFILL: if (cnt_r == FILL_W'(SEG_WORDS - 1)) state_nxt = S_SPSQ;
      S_SPSQ:  state_nxt = S_SPCMP;
      S_SPCMP: begin
        if (p_r <= PRIME_W'(BASE_LIMIT) && pp_r <= PSQ_W'(seg_end_r)) begin
          state_nxt = (p_r == PRIME_W'(2)) ? S_SDIV : S_SPRD;
        end else begin
          seg_valid_nxt = 1'b1;
          state_nxt     = S_SLOOK;
        end
      end
      S_SPRD:  state_nxt = b_rdata[p_r[6:1]] ? S_SDIV : S_SPSQ;
      S_SDIV:  state_nxt = rem_go ? S_SWAIT : S_SJ;
      S_SWAIT: if (rem_done) state_nxt = S_SJ;
      S_SJ:    state_nxt = (j_r <= {1'b0, seg_end_r}) ? S_SRMW : S_SPSQ;
      S_SRMW:  state_nxt = S_SJ;
      S_SLOOK: state_nxt = S_SANS;
      S_SANS:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      base_ready_r <= 1'b0;
      seg_valid_r  <= 1'b0;
      seg_start_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      base_ready_r <= base_ready_nxt;
      seg_valid_r  <= seg_valid_nxt;
      seg_start_r  <= seg_start_nxt;
      out_valid_r  <= ((state_r == S_CHK) && reject) || (state_r == S_BANS) ||
                      (state_r == S_SANS);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) n_r <= in_query_value;
    if (state_r == S_CHK)  out_prime_r <= 1'b0;
    if (state_r == S_BANS) out_prime_r <= b_rdata[n_r[6:1]];
    if (state_r == S_SANS) out_prime_r <= s_rdata[n_idx[5:0]];
    if (state_r == S_SEND) begin
      seg_end_r <= (seg_start_r > LIM_HI) ? MXV - VW'(1) : seg_start_r + SPANV;
    end
    if (state_r == S_CHK || state_r == S_LOOK) cnt_r <= '0;
    else if (state_r == S_BFILL || state_r == S_SFILL) cnt_r <= cnt_r + 1'b1;
    // prime walk: 3.. for the base sieve, 2,3,5.. for a segment
    if (state_r == S_BFILL)      p_r <= PRIME_W'(3);
    else if (state_r == S_SFILL) p_r <= PRIME_W'(2);
    else if ((state_r == S_BPRD && !b_rdata[p_r[6:1]]) ||
             (state_r == S_SPRD && !b_rdata[p_r[6:1]]) ||
             (state_r == S_BJ && j_r > (VW+1)'(BASE_LIMIT)) ||
             (state_r == S_SJ && j_r > {1'b0, seg_end_r})) begin
      p_r <= p_next;
    end
    if (state_r == S_BPSQ || state_r == S_SPSQ) pp_r <= p_r * p_r;
    if (state_r == S_BPRD || (state_r == S_SDIV && !rem_go)) j_r <= (VW+1)'(pp_r);
    else if (state_r == S_SWAIT && rem_done) j_r <= x_num - (VW+1)'(rem_val);
    else if (state_r == S_BRMW) j_r <= j_r + (VW+1)'({p_r, 1'b0});
    else if (state_r == S_SRMW) j_r <= j_r + (VW+1)'(p_r);
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

`ifndef SYNTHESIS
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("answer strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted query did not raise busy");
  a_seg_base: assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid_r |-> base_ready_r) else $error("segment valid without base bitmap");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("answer given while still busy");
`endif
endmodule

// ===== verif/segmented_sieve_prime_test_top_tb.sv =====
// Testbench for the segmented sieve prime tester: directed and random queries, self-checked.
module segmented_sieve_prime_test_top_tb;
  localparam int          VALUE_BITS   = 32;
  localparam int          BASE_LIMIT   = 65535;
  localparam int          SEGMENT_SPAN = 65535;
  localparam longint      MAXV         = (64'd1 << VALUE_BITS) - 1;
  localparam int          NUM_RANDOM   = 680;
  localparam int          MAX_JUMPS    = 4;
  localparam int          STALL_LIMIT  = 4000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_query_value;
  logic        out_valid;
  logic        out_is_prime;

  segmented_sieve_prime_test_top #(
    .VALUE_BITS(VALUE_BITS), .BASE_LIMIT(BASE_LIMIT), .SEGMENT_SPAN(SEGMENT_SPAN)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_query_value(in_query_value), .out_valid(out_valid), .out_is_prime(out_is_prime)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  logic [31:0] query_queue[$];
  bit          answer_queue[$];
  int          total_queries;
  int          accepted_queries;
  int          answers_seen;
  int          primes_seen;
  int          rebuilds_seen;
  int          errors;
  int          stall_cycles;

  // odd-number sieve: bit k stands for 2k+1
  bit          odd_sieve[0:32767];
  int unsigned small_primes[$];
  bit          sieve_built;
  bit          seg_live;
  logic [31:0] seg_base;
  bit          gen_seg_live;
  logic [31:0] gen_seg_base;

  function automatic void build_odd_sieve();
    longint p, j;
    for (int k = 0; k < 32768; k++) odd_sieve[k] = 1'b1;
    odd_sieve[0] = 1'b0;
    for (p = 3; p * p <= BASE_LIMIT; p += 2)
      if (odd_sieve[p >> 1])
        for (j = p * p; j <= BASE_LIMIT; j += 2 * p) odd_sieve[j >> 1] = 1'b0;
    small_primes = {};
    for (p = 3; p <= BASE_LIMIT; p += 2)
      if (odd_sieve[p >> 1]) small_primes.push_back(int'(p));
  endfunction

  function automatic bit trivially_zero(logic [31:0] n);
    return (n < 2) || (n[0] == 1'b0) || (longint'(n) >= MAXV - 3);
  endfunction

  // segment cache tracking; returns 1 when n forces a rebuild
  function automatic bit track_segment(inout bit live, inout logic [31:0] base,
                                       input logic [31:0] n);
    longint nv, a, last;
    nv = n;
    a  = 0;
    if (live) begin
      a    = base;
      last = (a > MAXV - SEGMENT_SPAN) ? MAXV - 1 : a + SEGMENT_SPAN;
      if (nv >= a && nv <= last) return 1'b0;
      live = 1'b0;
    end
    if (nv > a) a = (nv > MAXV - SEGMENT_SPAN) ? MAXV - SEGMENT_SPAN : nv;
    else if (nv < SEGMENT_SPAN) a = BASE_LIMIT - 1;
    else a = nv - (SEGMENT_SPAN - 2);
    live = 1'b1;
    base = a[31:0];
    return 1'b1;
  endfunction

  function automatic bit predict_prime(logic [31:0] n);
    longint nv, p;
    nv = n;
    if (trivially_zero(n)) return 1'b0;
    if (!sieve_built) begin
      build_odd_sieve();
      sieve_built = 1'b1;
    end
    if (nv < BASE_LIMIT) return odd_sieve[nv >> 1];
    if (track_segment(seg_live, seg_base, n)) rebuilds_seen++;
    foreach (small_primes[i]) begin
      p = small_primes[i];
      if (p * p > nv) break;
      if (nv % p == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit sender_idles();
    int phase;
    phase = (accepted_queries * 3) / (total_queries + 1);
    if (phase == 0) return $urandom_range(99) < 34;
    if (phase == 1) return $urandom_range(99) < 58;
    return 1'b0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start          <= 1'b0;
      in_query_value <= '0;
    end else begin
      if (start && !busy) begin
        answer_queue.push_back(predict_prime(in_query_value));
        accepted_queries++;
      end
      if (!start || !busy) begin
        if (query_queue.size() > 0 && !sender_idles()) begin
          start          <= 1'b1;
          in_query_value <= query_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        answers_seen++;
        if (answer_queue.size() == 0) begin
          $error("unexpected beat: is_prime actual %0b", out_is_prime);
          errors++;
        end else begin
          bit want;
          want = answer_queue.pop_front();
          if (want) primes_seen++;
          if (out_is_prime !== want) begin
            $error("is_prime mismatch: expected %0b actual %0b", want, out_is_prime);
            errors++;
          end
        end
      end
      if (out_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic void add_query(logic [31:0] n);
    if (!trivially_zero(n) && n >= BASE_LIMIT)
      void'(track_segment(gen_seg_live, gen_seg_base, n));
    query_queue.push_back(n);
  endfunction

  initial begin
    int          jumps;
    int          kind;
    logic [31:0] v;
    rst_n          = 1'b0;
    sieve_built    = 1'b0;
    seg_live       = 1'b0;
    seg_base       = '0;
    gen_seg_live   = 1'b0;
    gen_seg_base   = '0;
    errors = 0; accepted_queries = 0; answers_seen = 0;
    primes_seen = 0; rebuilds_seen = 0; stall_cycles = 0;

    // trivial rejects before the base sieve exists
    add_query(32'd0); add_query(32'd1); add_query(32'd2); add_query(32'hFFFFFFFF);
    add_query(32'hFFFFFFFE);
    // base range, first real query triggers base build
    add_query(32'd3); add_query(32'd9); add_query(32'd65521); add_query(32'd65533);
    add_query(32'd65534);
    // first segment, forward from nothing
    add_query(32'd65535); add_query(32'd65537); add_query(32'd131069);
    // top of range: clamped start, then the near-max rejects
    add_query(32'd4294967291); add_query(32'd4294967293); add_query(32'd4294967292);
    add_query(32'd4294967295); add_query(32'd4294967289);
    // backward miss from the top
    add_query(32'd70001); add_query(32'd66001);
    add_query(32'h80000001); add_query(32'h80000003);

    jumps = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        v = $urandom_range(BASE_LIMIT - 1);
        v[0] = 1'b1;
      end else if (kind < 45) begin
        v = $urandom;
        v[0] = 1'b0;
        if ($urandom_range(9) == 0) v = 32'hFFFFFFFC + $urandom_range(3);
      end else if (kind < 97 || jumps >= MAX_JUMPS) begin
        v = gen_seg_base + $urandom_range(SEGMENT_SPAN);
        v[0] = 1'b1;
        if (longint'(v) >= MAXV - 3) v = 32'hFFFFFFFB;
        if (v < BASE_LIMIT) v = BASE_LIMIT;
      end else begin
        v = $urandom;
        v[0] = 1'b1;
        if (!trivially_zero(v) && v >= BASE_LIMIT) jumps++;
      end
      add_query(v);
    end
    total_queries = query_queue.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (query_queue.size() != 0 || start || answer_queue.size() != 0);
    repeat (20) @(posedge clk);

    if (answer_queue.size() != 0) begin
      $error("%0d answers never arrived", answer_queue.size());
      errors++;
    end
    $display("%0d queries, %0d answers (%0d prime), %0d segment rebuilds",
             accepted_queries, answers_seen, primes_seen, rebuilds_seen);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
